FILE: sv/osl_ic_pkg.sv
package osl_ic_pkg;

    localparam int TRANSFER_WIDTH  = 32;
    localparam int IMPEDANCE_WIDTH = 48;
    localparam int EPS_WIDTH       = 31;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  =
        (IMPEDANCE_WIDTH > TRANSFER_WIDTH) ? IMPEDANCE_WIDTH : TRANSFER_WIDTH;
    localparam logic [EPS_WIDTH-1:0] EPS_RESET = EPS_WIDTH'(168);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_OPEN_RE  = 3'd0,
        REG_OPEN_IM  = 3'd1,
        REG_SHORT_RE = 3'd2,
        REG_SHORT_IM = 3'd3,
        REG_K_RE     = 3'd4,
        REG_K_IM     = 3'd5,
        REG_EPS      = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_ILL = 2'd1,
        ST_OVF = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [TRANSFER_WIDTH-1:0] t_re;
        logic signed [TRANSFER_WIDTH-1:0] t_im;
    } meas_item_t;

    typedef struct packed {
        logic signed [IMPEDANCE_WIDTH-1:0] z_re;
        logic signed [IMPEDANCE_WIDTH-1:0] z_im;
        status_t                           status;
    } imp_item_t;

endpackage

FILE: sv/osl_impedance_correction_unit.sv
// Channel | Direction | Handshake               | Beat
// meas    | in        | meas_valid / meas_ready | measured transfer t_re, t_im (Q8.24)
// imp     | out       | imp_valid / imp_ready   | impedance z_re, z_im (Q32.16), status
// cfg     | in        | cfg_we, cfg_index       | cfg_wdata, no wait, no read-back
//
// One beat enters per cycle while the queue has room; the pipeline depth is set mostly
// by the restoring divider, which retires one quotient bit per stage. A two-entry
// output queue holds results while imp_ready is low; the whole pipeline freezes only
// when that queue is full. rst_n clears the valid bits, the queue and the calibration
// registers (threshold back to its default).
module osl_impedance_correction_unit
    import osl_ic_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        meas_valid,
    output logic                        meas_ready,
    input  meas_item_t                  meas,
    output logic                        imp_valid,
    input  logic                        imp_ready,
    output imp_item_t                   imp,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]   cfg_wdata
);

    localparam int TW   = TRANSFER_WIDTH;
    localparam int IW   = IMPEDANCE_WIDTH;
    localparam int DW   = TW + 1;
    localparam int MPW  = 2 * DW;
    localparam int DENW = MPW;
    localparam int PW   = MPW + 1;
    localparam int KLW  = IW / 2;
    localparam int KHW  = IW - KLW;
    localparam int PLW  = PW / 2;
    localparam int PHW  = PW - PLW;
    localparam int HHW  = KHW + PHW;
    localparam int HLW  = KHW + PLW + 1;
    localparam int LHW  = KLW + 1 + PHW;
    localparam int LLW  = KLW + PLW + 2;
    localparam int FW   = IW + PW;
    localparam int AW   = FW + 1;
    localparam int HIW  = AW - IW;
    localparam int CW   = (DW > EPS_WIDTH) ? DW : EPS_WIDTH;
    localparam int NST  = IW + 11;

    // Calibration registers.
    logic signed [TW-1:0]        open_re_reg, open_im_reg, short_re_reg, short_im_reg;
    logic signed [IW-1:0]        k_re_reg, k_im_reg;
    logic        [EPS_WIDTH-1:0] eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_re_reg  <= '0;
            open_im_reg  <= '0;
            short_re_reg <= '0;
            short_im_reg <= '0;
            k_re_reg     <= '0;
            k_im_reg     <= '0;
            eps_reg      <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OPEN_RE:  open_re_reg  <= cfg_wdata[TW-1:0];
                REG_OPEN_IM:  open_im_reg  <= cfg_wdata[TW-1:0];
                REG_SHORT_RE: short_re_reg <= cfg_wdata[TW-1:0];
                REG_SHORT_IM: short_im_reg <= cfg_wdata[TW-1:0];
                REG_K_RE:     k_re_reg     <= cfg_wdata[IW-1:0];
                REG_K_IM:     k_im_reg     <= cfg_wdata[IW-1:0];
                REG_EPS:      eps_reg      <= cfg_wdata[EPS_WIDTH-1:0];
                default:      ;
            endcase
        end
    end

    // Pipeline control.
    logic [NST-1:0] v_reg;
    logic           en;
    logic [1:0]     cnt_reg;
    logic           wr_ptr_reg, rd_ptr_reg;
    imp_item_t      buf_reg [0:1];
    imp_item_t      res_reg;
    logic           push, pop;

    assign en         = (cnt_reg != 2'd2);
    assign meas_ready = en;
    assign push       = en && v_reg[NST-1];
    assign imp_valid  = (cnt_reg != 2'd0);
    assign pop        = imp_valid && imp_ready;
    assign imp        = buf_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v_reg <= {v_reg[NST-2:0], meas_valid};
            end
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= res_reg;
        end
    end

    // Datapath registers.
    logic signed [DW-1:0]   d_re_reg, d_im_reg, n_re_reg, n_im_reg;
    logic signed [MPW-1:0]  sq_re_reg, sq_im_reg, nrdr_reg, nidi_reg, nidr_reg, nrdi_reg;
    logic                   ill_reg [1:NST-3];
    logic        [DENW-1:0] den_reg [2:NST-3];
    logic signed [PW-1:0]   p_re_reg, p_im_reg;
    logic signed [HHW-1:0]  hh_reg [0:1][0:1];
    logic signed [HLW-1:0]  hl_reg [0:1][0:1];
    logic signed [LHW-1:0]  lh_reg [0:1][0:1];
    logic signed [LLW-1:0]  ll_reg [0:1][0:1];
    logic signed [FW-1:0]   x_reg [0:1][0:1];
    logic signed [FW-1:0]   y_reg [0:1][0:1];
    logic signed [FW-1:0]   prod_reg [0:1][0:1];
    logic signed [AW-1:0]   a_reg [0:1];
    logic        [AW-1:0]   m_reg [0:1];
    logic                   neg_reg [0:1];

    // Divider stages: index 0 is the setup stage, index j retires quotient bit IW-j.
    logic [DENW-1:0] drem_reg [0:IW][0:1];
    logic [IW-1:0]   dbits_reg [0:IW][0:1];
    logic [IW-1:0]   dq_reg [0:IW][0:1];
    logic            dovf_reg [0:IW][0:1];
    logic            dneg_reg [0:IW][0:1];

    logic [IW:0]     qr_reg [0:1];
    logic            rovf_reg [0:1];
    logic            rneg_reg [0:1];
    logic            rill_reg;

    // Combinational next values.
    logic [DW-1:0]          abs_re, abs_im;
    logic                   ill_next;
    logic signed [IW-1:0]   k_arr [0:1];
    logic signed [PW-1:0]   p_arr [0:1];
    logic [HIW-1:0]         hi_part [0:1];
    logic [DENW:0]          trial [1:IW][0:1];
    logic                   take [1:IW][0:1];
    logic [DENW-1:0]        rem_next [1:IW][0:1];
    logic                   up [0:1];
    logic [IW:0]            lim [0:1];
    logic                   sat [0:1];
    logic [IW:0]            mag [0:1];
    logic [IW:0]            zval [0:1];
    imp_item_t              res_next;

    always_comb
    begin
        abs_re   = d_re_reg[DW-1] ? $unsigned(-d_re_reg) : $unsigned(d_re_reg);
        abs_im   = d_im_reg[DW-1] ? $unsigned(-d_im_reg) : $unsigned(d_im_reg);
        ill_next = (CW'(abs_re) < CW'(eps_reg) && CW'(abs_im) < CW'(eps_reg)) ||
                   (d_re_reg == '0 && d_im_reg == '0);

        k_arr[0] = k_re_reg;
        k_arr[1] = k_im_reg;
        p_arr[0] = p_re_reg;
        p_arr[1] = p_im_reg;

        for (int c = 0; c < 2; c++)
        begin
            hi_part[c] = m_reg[c][AW-1:IW];
        end

        for (int j = 1; j <= IW; j++)
        begin
            for (int c = 0; c < 2; c++)
            begin
                trial[j][c] = {drem_reg[j-1][c], dbits_reg[j-1][c][IW-1]};
                take[j][c]  = (trial[j][c] >= {1'b0, den_reg[8+j-1]});
                rem_next[j][c] = take[j][c] ?
                    DENW'(trial[j][c] - {1'b0, den_reg[8+j-1]}) : trial[j][c][DENW-1:0];
            end
        end

        for (int c = 0; c < 2; c++)
        begin
            up[c]  = ({drem_reg[IW][c], 1'b0} >= {1'b0, den_reg[8+IW]});
            lim[c] = rneg_reg[c] ? ((IW+1)'(1) << (IW-1))
                                 : (((IW+1)'(1) << (IW-1)) - (IW+1)'(1));
            sat[c] = rovf_reg[c] || (qr_reg[c] > lim[c]);
            mag[c] = sat[c] ? lim[c] : qr_reg[c];
            zval[c] = rneg_reg[c] ? -mag[c] : mag[c];
        end

        if (rill_reg)
        begin
            res_next.z_re   = '0;
            res_next.z_im   = '0;
            res_next.status = ST_ILL;
        end
        else
        begin
            res_next.z_re   = zval[0][IW-1:0];
            res_next.z_im   = zval[1][IW-1:0];
            res_next.status = (sat[0] || sat[1]) ? ST_OVF : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Differences against the open and short standards.
            d_re_reg <= DW'(meas.t_re) - DW'(open_re_reg);
            d_im_reg <= DW'(meas.t_im) - DW'(open_im_reg);
            n_re_reg <= DW'(meas.t_re) - DW'(short_re_reg);
            n_im_reg <= DW'(meas.t_im) - DW'(short_im_reg);

            sq_re_reg <= MPW'(d_re_reg) * MPW'(d_re_reg);
            sq_im_reg <= MPW'(d_im_reg) * MPW'(d_im_reg);
            nrdr_reg  <= MPW'(n_re_reg) * MPW'(d_re_reg);
            nidi_reg  <= MPW'(n_im_reg) * MPW'(d_im_reg);
            nidr_reg  <= MPW'(n_im_reg) * MPW'(d_re_reg);
            nrdi_reg  <= MPW'(n_re_reg) * MPW'(d_im_reg);
            ill_reg[1] <= ill_next;

            // |d|^2 and n * conj(d).
            den_reg[2] <= $unsigned(sq_re_reg) + $unsigned(sq_im_reg);
            p_re_reg   <= PW'(nrdr_reg) + PW'(nidi_reg);
            p_im_reg   <= PW'(nidr_reg) - PW'(nrdi_reg);
            ill_reg[2] <= ill_reg[1];

            // k * p split into four partial products per pair of operands.
            for (int i = 0; i < 2; i++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    hh_reg[i][j] <= HHW'($signed(k_arr[i][IW-1:KLW])) *
                                    HHW'($signed(p_arr[j][PW-1:PLW]));
                    hl_reg[i][j] <= HLW'($signed(k_arr[i][IW-1:KLW])) *
                                    HLW'($signed({1'b0, p_arr[j][PLW-1:0]}));
                    lh_reg[i][j] <= LHW'($signed({1'b0, k_arr[i][KLW-1:0]})) *
                                    LHW'($signed(p_arr[j][PW-1:PLW]));
                    ll_reg[i][j] <= LLW'($signed({1'b0, k_arr[i][KLW-1:0]})) *
                                    LLW'($signed({1'b0, p_arr[j][PLW-1:0]}));
                    x_reg[i][j]  <= (FW'(hh_reg[i][j]) <<< (KLW + PLW)) +
                                    (FW'(lh_reg[i][j]) <<< PLW);
                    y_reg[i][j]  <= (FW'(hl_reg[i][j]) <<< KLW) + FW'(ll_reg[i][j]);
                    prod_reg[i][j] <= x_reg[i][j] + y_reg[i][j];
                end
            end
            for (int s = 3; s <= 6; s++)
            begin
                den_reg[s] <= den_reg[s-1];
                ill_reg[s] <= ill_reg[s-1];
            end

            a_reg[0] <= AW'(prod_reg[0][0]) - AW'(prod_reg[1][1]);
            a_reg[1] <= AW'(prod_reg[0][1]) + AW'(prod_reg[1][0]);
            den_reg[7] <= den_reg[6];
            ill_reg[7] <= ill_reg[6];

            // Sign and magnitude of the dividends.
            for (int c = 0; c < 2; c++)
            begin
                neg_reg[c] <= a_reg[c][AW-1];
                m_reg[c]   <= a_reg[c][AW-1] ? $unsigned(-a_reg[c]) : $unsigned(a_reg[c]);
            end
            den_reg[8] <= den_reg[7];
            ill_reg[8] <= ill_reg[7];

            // Divider setup: a quotient that needs more than IW bits saturates anyway.
            for (int c = 0; c < 2; c++)
            begin
                dovf_reg[0][c]  <= (hi_part[c] >= HIW'(den_reg[7]));
                drem_reg[0][c]  <= hi_part[c][DENW-1:0];
                dbits_reg[0][c] <= m_reg[c][IW-1:0];
                dq_reg[0][c]    <= '0;
                dneg_reg[0][c]  <= neg_reg[c];
            end
            den_reg[9] <= den_reg[8];
            ill_reg[9] <= ill_reg[8];

            for (int j = 1; j <= IW; j++)
            begin
                for (int c = 0; c < 2; c++)
                begin
                    drem_reg[j][c]  <= rem_next[j][c];
                    dbits_reg[j][c] <= {dbits_reg[j-1][c][IW-2:0], 1'b0};
                    dq_reg[j][c]    <= {dq_reg[j-1][c][IW-2:0], take[j][c]};
                    dovf_reg[j][c]  <= dovf_reg[j-1][c];
                    dneg_reg[j][c]  <= dneg_reg[j-1][c];
                end
            end
            for (int s = 10; s <= NST-3; s++)
            begin
                den_reg[s] <= den_reg[s-1];
                ill_reg[s] <= ill_reg[s-1];
            end

            // Round to nearest, ties away from zero.
            for (int c = 0; c < 2; c++)
            begin
                qr_reg[c]   <= {1'b0, dq_reg[IW][c]} + (IW+1)'(up[c]);
                rovf_reg[c] <= dovf_reg[IW][c];
                rneg_reg[c] <= dneg_reg[IW][c];
            end
            rill_reg <= ill_reg[8+IW];

            res_reg <= res_next;
        end
    end

endmodule

FILE: tb/osl_ic_checker.sv
`timescale 1ns / 1ps

module osl_ic_checker
    import osl_ic_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       meas_valid,
    input  logic                       meas_ready,
    input  meas_item_t                 meas,
    input  logic                       imp_valid,
    input  logic                       imp_ready,
    input  imp_item_t                  imp,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
    output int                         fail_count,
    output int                         pending_count
);

    // Products reach about 48 + 2*33 bits; 256 bits leave ample headroom.
    typedef logic signed [255:0] wide_t;

    logic signed [TRANSFER_WIDTH-1:0]  cal_open_re, cal_open_im;
    logic signed [TRANSFER_WIDTH-1:0]  cal_short_re, cal_short_im;
    logic signed [IMPEDANCE_WIDTH-1:0] cal_k_re, cal_k_im;
    logic [EPS_WIDTH-1:0]              cal_eps;

    imp_item_t expected_imp[$];
    int        mismatches;

    assign fail_count    = mismatches;
    assign pending_count = expected_imp.size();

    function automatic logic [IMPEDANCE_WIDTH-1:0] round_div_clamp(wide_t num, wide_t den,
                                                                   inout logic sat);
        wide_t mag, q, r, lim;
        logic  neg;
        begin
            neg = num < 0;
            mag = neg ? -num : num;
            q   = mag / den;
            r   = mag % den;
            if (2 * r >= den)
                q = q + 1;
            lim = wide_t'(1) <<< (IMPEDANCE_WIDTH - 1);
            if (!neg)
                lim = lim - 1;
            if (q > lim)
            begin
                q   = lim;
                sat = 1'b1;
            end
            if (neg)
                q = -q;
            return q[IMPEDANCE_WIDTH-1:0];
        end
    endfunction

    function automatic imp_item_t correct_impedance(meas_item_t m);
        wide_t     d_re, d_im, n_re, n_im, den, p_re, p_im, a_re, a_im, eps, ad_re, ad_im;
        logic      sat;
        imp_item_t z;
        begin
            d_re  = wide_t'(m.t_re) - wide_t'(cal_open_re);
            d_im  = wide_t'(m.t_im) - wide_t'(cal_open_im);
            n_re  = wide_t'(m.t_re) - wide_t'(cal_short_re);
            n_im  = wide_t'(m.t_im) - wide_t'(cal_short_im);
            eps   = wide_t'({1'b0, cal_eps});
            ad_re = d_re < 0 ? -d_re : d_re;
            ad_im = d_im < 0 ? -d_im : d_im;
            den   = d_re * d_re + d_im * d_im;
            z     = '0;
            sat   = 1'b0;
            if ((ad_re < eps && ad_im < eps) || den == 0)
            begin
                z.status = ST_ILL;
                return z;
            end
            p_re = n_re * d_re + n_im * d_im;
            p_im = n_im * d_re - n_re * d_im;
            a_re = wide_t'(cal_k_re) * p_re - wide_t'(cal_k_im) * p_im;
            a_im = wide_t'(cal_k_re) * p_im + wide_t'(cal_k_im) * p_re;
            z.z_re   = round_div_clamp(a_re, den, sat);
            z.z_im   = round_div_clamp(a_im, den, sat);
            z.status = sat ? ST_OVF : ST_OK;
            return z;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        imp_item_t want;
        if (!rst_n)
        begin
            cal_open_re  = '0;
            cal_open_im  = '0;
            cal_short_re = '0;
            cal_short_im = '0;
            cal_k_re     = '0;
            cal_k_im     = '0;
            cal_eps      = EPS_RESET;
            expected_imp.delete();
            mismatches   = 0;
        end
        else
        begin
            // The result leaving now was predicted from earlier beats, so check first.
            if (imp_valid && imp_ready)
            begin
                if (expected_imp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat %p", $realtime, imp);
                end
                else
                begin
                    want = expected_imp.pop_front();
                    if (imp.z_re !== want.z_re || imp.z_im !== want.z_im ||
                        imp.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch, expected z=(%0d, %0d) status %s, got z=(%0d, %0d) status %0d",
                                     $realtime, want.z_re, want.z_im, want.status.name(),
                                     imp.z_re, imp.z_im, imp.status);
                    end
                end
            end
            if (meas_valid && meas_ready)
                expected_imp.push_back(correct_impedance(meas));
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_OPEN_RE:  cal_open_re  = cfg_wdata[TRANSFER_WIDTH-1:0];
                    REG_OPEN_IM:  cal_open_im  = cfg_wdata[TRANSFER_WIDTH-1:0];
                    REG_SHORT_RE: cal_short_re = cfg_wdata[TRANSFER_WIDTH-1:0];
                    REG_SHORT_IM: cal_short_im = cfg_wdata[TRANSFER_WIDTH-1:0];
                    REG_K_RE:     cal_k_re     = cfg_wdata[IMPEDANCE_WIDTH-1:0];
                    REG_K_IM:     cal_k_im     = cfg_wdata[IMPEDANCE_WIDTH-1:0];
                    REG_EPS:      cal_eps      = cfg_wdata[EPS_WIDTH-1:0];
                    default:      ;
                endcase
            end
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import osl_ic_pkg::*;

    localparam int LATENCY     = IMPEDANCE_WIDTH + 11;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 230;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       meas_valid = 1'b0;
    logic                       meas_ready;
    meas_item_t                 meas = '0;
    logic                       imp_valid;
    logic                       imp_ready = 1'b0;
    imp_item_t                  imp;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;

    int fail_count;
    int pending_count;
    bit quiet_tail = 1'b0;
    bit long_hold  = 1'b0;
    bit stimulus_done = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    osl_impedance_correction_unit uut (.*);

    osl_ic_checker checker_i (.*);

    initial
    begin
        #50_000_000;
        $display("FAIL osl_impedance_correction_unit");
        $finish;
    end

    // Receiver: random stall bursts, a long hold-off on request, none at the end.
    always @(posedge clk)
    begin
        int gap;
        if (rst_n && !stimulus_done)
        begin
            if (long_hold)
            begin
                imp_ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
                imp_ready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(1, 17);
                imp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                imp_ready <= 1'b1;
            end
            else
                imp_ready <= 1'b1;
        end
        else if (stimulus_done)
            imp_ready <= 1'b1;
    end

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_meas(logic [TRANSFER_WIDTH-1:0] re, logic [TRANSFER_WIDTH-1:0] im);
        meas_valid <= 1'b1;
        meas.t_re  <= re;
        meas.t_im  <= im;
        @(posedge clk);
        while (!meas_ready)
            @(posedge clk);
    endtask

    task automatic sender_gap();
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            meas_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic drain();
        meas_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic [TRANSFER_WIDTH-1:0] rand_transfer();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000 + $urandom_range(0, 3);
            1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2:       return $urandom_range(0, 600) - 300;
            3:       return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] rand_scale();
        case ($urandom_range(0, 3))
            0:       return 48'h7FFF_FFFF_FFFF;
            1:       return 48'h8000_0000_0000;
            2:       return CFG_DATA_WIDTH'(($signed($urandom_range(0, 2000)) - 1000) * 65536);
            default: return CFG_DATA_WIDTH'({$urandom, $urandom});
        endcase
    endfunction

    // Transfers that land near t_open (ill-conditioned for a large enough threshold), near t_short, or anywhere.
    task automatic random_beat(logic [TRANSFER_WIDTH-1:0] o_re, logic [TRANSFER_WIDTH-1:0] o_im,
                               logic [TRANSFER_WIDTH-1:0] s_re, logic [TRANSFER_WIDTH-1:0] s_im);
        case ($urandom_range(0, 5))
            0:       send_meas(o_re + $urandom_range(0, 400) - 200,
                               o_im + $urandom_range(0, 400) - 200);
            1:       send_meas(s_re + $urandom_range(0, 64) - 32, s_im);
            default: send_meas(rand_transfer(), rand_transfer());
        endcase
        sender_gap();
    endtask

    initial
    begin
        logic [TRANSFER_WIDTH-1:0] o_re, o_im, s_re, s_im;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: k is zero, so every well-conditioned beat gives zero.
        send_meas(32'h0100_0000, 32'h0);
        send_meas(32'h0, 32'h0);
        send_meas(32'h0000_00A7, 32'hFFFF_FF59);
        send_meas(32'h0000_00A8, 32'h0);
        drain();

        write_reg(REG_OPEN_RE, 32'h0100_0000);
        write_reg(REG_OPEN_IM, 32'h0);
        write_reg(REG_SHORT_RE, 32'hFF00_0000);
        write_reg(REG_SHORT_IM, 32'h0);
        write_reg(REG_K_RE, 48'h0000_0032_0000);
        write_reg(REG_K_IM, 48'h0000_0001_8000);
        write_reg(REG_EPS, 31'd0);
        write_reg(cfg_idx_t'(3'd7), 48'hFFFF_FFFF_FFFF);
        send_meas(32'h0100_0000, 32'h0);
        send_meas(32'h0100_0001, 32'h0);
        send_meas(32'hFF00_0000, 32'h0);
        send_meas(32'h0, 32'h0);
        send_meas(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_meas(32'h8000_0000, 32'h8000_0000);
        send_meas(32'h7FFF_FFFF, 32'h8000_0000);
        send_meas(32'h8000_0000, 32'h0);
        drain();
        write_reg(REG_K_RE, 48'h7FFF_FFFF_FFFF);
        write_reg(REG_K_IM, 48'h8000_0000_0000);
        write_reg(REG_EPS, 31'h7FFF_FFFF);
        send_meas(32'h0100_0000, 32'h0100_0000);
        send_meas(32'h7FFF_FFFF, 32'h0);
        drain();
        write_reg(REG_EPS, 31'd168);
        send_meas(32'h0100_0002, 32'h0);
        send_meas(32'h8000_0000, 32'h7FFF_FFFF);
        send_meas(32'h0000_00FF, 32'h0100_0000);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            o_re = rand_transfer();
            o_im = rand_transfer();
            s_re = rand_transfer();
            s_im = rand_transfer();
            write_reg(REG_OPEN_RE, o_re);
            write_reg(REG_OPEN_IM, o_im);
            write_reg(REG_SHORT_RE, s_re);
            write_reg(REG_SHORT_IM, s_im);
            write_reg(REG_K_RE, rand_scale());
            write_reg(REG_K_IM, rand_scale());
            case (p % 3)
                0:       write_reg(REG_EPS, $urandom_range(0, 400));
                1:       write_reg(REG_EPS, 31'h7FFF_FFFF);
                default: write_reg(REG_EPS, $urandom & 31'h7FFF_FFFF);
            endcase
            if (p == PHASES - 1)
                quiet_tail = 1'b1;
            for (int i = 0; i < PHASE_BEATS; i++)
            begin
                if (p == 2 && i == 20)
                    long_hold = 1'b1;
                // One pause until every result is back, mid-phase.
                if (p == 4 && i == 100)
                begin
                    meas_valid <= 1'b0;
                    while (pending_count != 0)
                        @(posedge clk);
                end
                random_beat(o_re, o_im, s_re, s_im);
            end
        end
        meas_valid <= 1'b0;
        stimulus_done = 1'b1;
        fork
            begin
                while (pending_count != 0)
                    @(posedge clk);
                repeat (LATENCY + 5) @(posedge clk);
            end
            begin
                repeat (200_000) @(posedge clk);
                $display("FAIL osl_impedance_correction_unit");
                $finish;
            end
        join_any
        if (fail_count == 0)
            $display("PASS osl_impedance_correction_unit");
        else
            $display("FAIL osl_impedance_correction_unit");
        $finish;
    end

endmodule
